// ===== design/led_pkg.sv =====
// ----------------------------------------------------------------------------
// led_pkg
// Shared constants, codes and controller/datapath types for the line editor.
// ----------------------------------------------------------------------------
package led_pkg;

	localparam int BUF_LEN     = 32;
	localparam int STORE_DEPTH = BUF_LEN - 1;
	localparam int CNT_W       = $clog2(BUF_LEN);
	localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_ECHO_ENABLE = '0;

	localparam logic       REQ_BYTE = 1'b0;
	localparam logic       REQ_EOI  = 1'b1;

	localparam logic [1:0] KIND_ECHO      = 2'd0;
	localparam logic [1:0] KIND_LINE      = 2'd1;
	localparam logic [1:0] KIND_EMPTY_END = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7f;

	typedef enum logic [1:0] {
		SRC_CONST,
		SRC_CHAR,
		SRC_LINE
	} led_src_t;

	typedef struct packed {
		logic       capture;
		logic       store;
		logic       fill_dec;
		logic       emit;
		led_src_t   src;
		logic [1:0] kind;
		logic [7:0] const_byte;
		logic       last;
		logic       ptr_adv;
		logic       line_done;
	} led_cmd_t;

	typedef struct packed {
		logic is_eoi;
		logic is_crlf;
		logic is_erase;
		logic is_print;
		logic fill_zero;
		logic fill_full;
		logic echo_on;
		logic out_free;
		logic line_last;
	} led_sts_t;

endpackage

// ===== design/led_intf.sv =====
// ----------------------------------------------------------------------------
// led_in_if / led_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface led_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface led_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_kind, output out_byte, output last,
		input ready);
	modport sink (input valid, input out_kind, input out_byte, input last,
		output ready);
endinterface

// ===== design/led_regs.sv =====
// ----------------------------------------------------------------------------
// led_regs
// APB register file: holds the echo enable bit.
// ----------------------------------------------------------------------------
module led_regs
	import led_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic               echo_en
);

	logic echo_q;
	logic sel_echo;

	assign sel_echo = (paddr[PADDR_W-1:2] == REG_ECHO_ENABLE);
	assign pready   = 1'b1;
	assign echo_en  = echo_q;
	assign prdata   = sel_echo ? {31'd0, echo_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q <= 1'b1;
		end else if (psel && penable && pwrite && sel_echo) begin
			echo_q <= pwdata[0];
		end
	end

endmodule

// ===== design/led_dp.sv =====
// ----------------------------------------------------------------------------
// led_dp
// Datapath: captured item, line store, fill count, read pointer, output reg.
// ----------------------------------------------------------------------------
module led_dp
	import led_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_type,
	input  logic [7:0] data_byte,
	input  logic       echo_en,
	input  led_cmd_t   cmd,
	output led_sts_t   sts,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       last
);

	logic             req_q;
	logic [7:0]       byte_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       mem [STORE_DEPTH];

	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       obyte_q;
	logic             last_q;
	logic [7:0]       emit_byte;
	logic             out_free;
	logic [CNT_W:0]   ptr_next;

	assign out_free = !out_valid_q || out_ready;
	assign ptr_next = {1'b0, rd_ptr_q} + 1'b1;

	always_comb begin
		sts.is_eoi    = (req_q == REQ_EOI);
		sts.is_crlf   = (byte_q == CH_CR) || (byte_q == CH_LF);
		sts.is_erase  = (byte_q == CH_BS) || (byte_q == CH_DEL);
		sts.is_print  = (byte_q >= CH_SPACE) && (byte_q != CH_DEL);
		sts.fill_zero = (fill_q == '0);
		sts.fill_full = (fill_q == CNT_W'(STORE_DEPTH));
		sts.echo_on   = echo_en;
		sts.out_free  = out_free;
		sts.line_last = (ptr_next == {1'b0, fill_q});
	end

	always_comb begin
		case (cmd.src)
			SRC_CONST: emit_byte = cmd.const_byte;
			SRC_CHAR:  emit_byte = byte_q;
			SRC_LINE:  emit_byte = rd_data_q;
			default:   emit_byte = CH_NUL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			byte_q <= data_byte;
		end
	end

	// line store: one write port at the fill count, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[fill_q[IDX_W-1:0]] <= byte_q;
		end
		rd_data_q <= mem[rd_ptr_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cmd.line_done) begin
				fill_q   <= '0;
				rd_ptr_q <= '0;
			end else begin
				if (cmd.store) begin
					fill_q <= fill_q + 1'b1;
				end else if (cmd.fill_dec) begin
					fill_q <= fill_q - 1'b1;
				end
				if (cmd.ptr_adv) begin
					rd_ptr_q <= ptr_next[CNT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && out_free) begin
			kind_q  <= cmd.kind;
			obyte_q <= emit_byte;
			last_q  <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_byte  = obyte_q;
	assign last      = last_q;

endmodule

// ===== design/led_ctrl.sv =====
// ----------------------------------------------------------------------------
// led_ctrl
// Controller: decodes the captured item and sequences echo and line results.
// ----------------------------------------------------------------------------
module led_ctrl
	import led_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  led_sts_t sts,
	output led_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CR,
		S_LF,
		S_BS1,
		S_SP,
		S_BS2,
		S_CHR,
		S_EMPTY,
		S_LINE_RD,
		S_LINE_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.src        = SRC_CONST;
		cmd.kind       = KIND_ECHO;
		cmd.const_byte = CH_NUL;
		state_d        = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				if (sts.is_eoi) begin
					state_d = sts.fill_zero ? S_EMPTY : S_LINE_RD;
				end else if (sts.is_crlf) begin
					if (!sts.fill_zero) begin
						state_d = sts.echo_on ? S_CR : S_LINE_RD;
					end
				end else if (sts.is_erase) begin
					if (!sts.fill_zero) begin
						cmd.fill_dec = 1'b1;
						if (sts.echo_on) begin
							state_d = S_BS1;
						end
					end
				end else if (sts.is_print && !sts.fill_full) begin
					cmd.store = 1'b1;
					if (sts.echo_on) begin
						state_d = S_CHR;
					end
				end
			end
			S_CR: begin
				cmd.emit       = 1'b1;
				cmd.const_byte = CH_CR;
				if (sts.out_free) begin
					state_d = S_LF;
				end
			end
			S_LF: begin
				cmd.emit       = 1'b1;
				cmd.const_byte = CH_LF;
				if (sts.out_free) begin
					state_d = S_LINE_RD;
				end
			end
			S_BS1: begin
				cmd.emit       = 1'b1;
				cmd.const_byte = CH_BS;
				if (sts.out_free) begin
					state_d = S_SP;
				end
			end
			S_SP: begin
				cmd.emit       = 1'b1;
				cmd.const_byte = CH_SPACE;
				if (sts.out_free) begin
					state_d = S_BS2;
				end
			end
			S_BS2: begin
				cmd.emit       = 1'b1;
				cmd.const_byte = CH_BS;
				cmd.last       = 1'b1;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_CHR: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_CHAR;
				cmd.last = 1'b1;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_EMPTY: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_EMPTY_END;
				cmd.last = 1'b1;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			// store read data is registered and lags the pointer
			S_LINE_RD: begin
				state_d = S_LINE_EMIT;
			end
			S_LINE_EMIT: begin
				cmd.emit = 1'b1;
				cmd.src  = SRC_LINE;
				cmd.kind = KIND_LINE;
				cmd.last = sts.line_last;
				if (sts.out_free) begin
					cmd.ptr_adv   = 1'b1;
					cmd.line_done = sts.line_last;
					state_d       = sts.line_last ? S_IDLE : S_LINE_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/line_editor_with_echo.sv =====
// ----------------------------------------------------------------------------
// line_editor_with_echo
// Builds a command line from received bytes, with echo and line-edit handling.
// Items are taken one at a time: a new item is accepted only once the controller
// is idle again after the last result of the previous one, and output
// back-pressure holds the sequence. Each item is captured, then decoded; line
// bytes are read through the registered read port of the line store before
// they reach the output register.
// Reset: asynchronous; line empties, echo enable returns to 1, no result held.
// ----------------------------------------------------------------------------
module line_editor_with_echo
	import led_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	led_in_if.sink             req_ch,
	led_out_if.source          res_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic     echo_en;
	led_cmd_t cmd;
	led_sts_t sts;

	led_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.echo_en (echo_en)
	);

	led_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req_ch.valid),
		.in_ready (req_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	led_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_type  (req_ch.req_type),
		.data_byte (req_ch.data_byte),
		.echo_en   (echo_en),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (res_ch.valid),
		.out_ready (res_ch.ready),
		.out_kind  (res_ch.out_kind),
		.out_byte  (res_ch.out_byte),
		.last      (res_ch.last)
	);

endmodule

// ===== design/led_chk.sv =====
// ----------------------------------------------------------------------------
// led_chk
// Port-level checks on the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module led_chk
	import led_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic       last
);

	// a result not taken stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// one item at a time: no new item right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accept");

	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_EMPTY_END |-> out_byte == CH_NUL && last)
		else $error("empty end result malformed");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_kind == KIND_ECHO || out_kind == KIND_LINE
			|| out_kind == KIND_EMPTY_END)
		else $error("undefined result kind");

	// CR echo is never marked last: LF always follows it
	a_cr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_ECHO && out_byte == CH_CR |-> !last)
		else $error("CR echo marked last");

endmodule

bind line_editor_with_echo led_chk u_led_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req_ch.valid),
	.in_ready  (req_ch.ready),
	.out_valid (res_ch.valid),
	.out_ready (res_ch.ready),
	.out_kind  (res_ch.out_kind),
	.out_byte  (res_ch.out_byte),
	.last      (res_ch.last)
);
